// File: rtl/core/bit_allocation_map_engine_top_assert.svh
// Assertion macros for the bit map engine
`ifndef BIT_ALLOCATION_MAP_ENGINE_TOP_ASSERT_SVH
`define BIT_ALLOCATION_MAP_ENGINE_TOP_ASSERT_SVH
`define BAME_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);
`define BAME_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
`endif

// File: rtl/core/bame_pkg.sv
// Shared types and codes for the bit map engine
package bame_pkg;
  localparam int NUM_W = 11;
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET_BIT = 3'd0, OP_FLIP_BIT = 3'd1, OP_TEST_BIT = 3'd2, OP_SET_RANGE = 3'd3,
    OP_COUNT = 3'd4, OP_CONTAINS = 3'd5, OP_SCAN = 3'd6, OP_SCAN_INV = 3'd7
  } op_t;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic [NUM_W-1:0] position;
    logic [NUM_W-1:0] span;
    logic polarity;
  } req_t;

  typedef struct packed {
    logic flag_out;
    logic [NUM_W-1:0] number_out;
    logic [ST_W-1:0] status;
  } rsp_t;
endpackage

// File: rtl/core/bame_if.sv
// Valid/ready channel interfaces for requests, results and configuration
interface bame_req_if import bame_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bame_rsp_if import bame_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bame_cfg_if import bame_pkg::*; ();
  logic valid;
  logic ready;
  logic [NUM_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bit_allocation_map_engine_top.sv
// Bit map engine top level: map store, bit-serial walker and result register
//
//   channel | dir | word
//   req     | in  | opcode, position, span, polarity
//   rsp     | out | flag_out, number_out, status
//   cfg     | in  | bits_in_use
//
// A result is offered once the walk is done: the shared one-bit compare/counter walks
// the N bits of the request, reading then evaluating each bit; range faults, empty
// ranges and trivial scans skip the walk; scan and invert then rewrites span bits.
// Reset clears the map word by word through all DEPTH words, no requests taken.
// req is not ready while an item is at work; a finished item waits while the
// previous result is still held in the output register.
module bit_allocation_map_engine_top
  import bame_pkg::*;
#(
  parameter int MAX_BITS = 1024,
  parameter int WORD_BITS = 32
) (
  input logic clk,
  input logic rst,
  bame_req_if.sink req,
  bame_rsp_if.source rsp,
  bame_cfg_if.sink cfg
);
  localparam int DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int KW = $clog2(MAX_BITS + 1) + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_READ, S_EVAL, S_INV, S_DONE}
    state_t;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;
  state_t state;
  logic [AW-1:0] clr_addr;
  logic [NUM_W-1:0] bits_in_use;
  op_t op;
  logic [KW-1:0] pos, span, k, stop, run, cnt;
  logic pol, inv_val;
  rsp_t res;
  rsp_t rsp_word;
  logic rsp_valid;

  logic [KW-1:0] lim;
  logic [KW-1:0] cfg_ext;
  assign cfg_ext = KW'(bits_in_use);
  assign lim = (cfg_ext > KW'(MAX_BITS)) ? KW'(MAX_BITS) : cfg_ext;

  logic [AW-1:0] k_word;
  logic [BW-1:0] k_bit;
  assign k_word = AW'(k / KW'(WORD_BITS));
  assign k_bit = BW'(k % KW'(WORD_BITS));

  logic cur_bit, match, wr_en, wr_val;
  assign cur_bit = rdata[k_bit];
  assign match = (cur_bit == pol);

  always_comb begin
    wr_en = 1'b0;
    wr_val = pol;
    if (state == S_EVAL) begin
      case (op)
        OP_SET_BIT, OP_SET_RANGE: wr_en = 1'b1;
        OP_FLIP_BIT: begin
          wr_en = 1'b1;
          wr_val = ~cur_bit;
        end
        default: wr_en = 1'b0;
      endcase
    end else if (state == S_INV) begin
      wr_en = 1'b1;
      wr_val = inv_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[k_word][k_bit] <= wr_val;
    end
    rdata <= mem[k_word];
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      bits_in_use <= NUM_W'(1024);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) bits_in_use <= cfg.data;
      if (rsp_valid && rsp.ready && state != S_DONE) rsp_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op <= op_t'(req.data.opcode);
            pos <= KW'(req.data.position);
            span <= KW'(req.data.span);
            pol <= req.data.polarity;
            res <= '0;
            run <= '0;
            cnt <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          k <= pos;
          state <= S_READ;
          case (op)
            OP_SET_BIT, OP_FLIP_BIT, OP_TEST_BIT: begin
              stop <= pos + KW'(1);
              if (pos >= lim) begin
                res.status <= ST_RANGE;
                state <= S_DONE;
              end
            end
            OP_SET_RANGE, OP_COUNT, OP_CONTAINS: begin
              stop <= pos + span;
              if (pos + span > lim) begin
                res.status <= ST_RANGE;
                state <= S_DONE;
              end else if (span == '0) begin
                state <= S_DONE;
              end
            end
            default: begin
              stop <= lim;
              if (pos > lim) begin
                res.status <= ST_RANGE;
                state <= S_DONE;
              end else if (span > lim) begin
                res.status <= ST_NOT_FOUND;
                state <= S_DONE;
              end else if (span == '0) begin
                res.number_out <= NUM_W'(pos);
                state <= S_DONE;
              end else if (pos >= lim) begin
                res.status <= ST_NOT_FOUND;
                state <= S_DONE;
              end
            end
          endcase
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          state <= S_READ;
          case (op)
            OP_TEST_BIT: res.flag_out <= cur_bit;
            OP_COUNT: res.number_out <= res.number_out + NUM_W'(match);
            OP_CONTAINS: if (match) res.flag_out <= 1'b1;
            OP_SCAN, OP_SCAN_INV: begin
              if (match && (run + KW'(1) == span)) begin
                res.number_out <= NUM_W'(k + KW'(1) - span);
                if (op == OP_SCAN_INV) begin
                  k <= k + KW'(1) - span;
                  cnt <= '0;
                  inv_val <= ~pol;
                  state <= S_INV;
                end else begin
                  state <= S_DONE;
                end
              end else begin
                run <= match ? run + KW'(1) : '0;
              end
            end
            default: ;
          endcase
          if (state != S_INV && !((op == OP_SCAN || op == OP_SCAN_INV) && match
              && (run + KW'(1) == span))) begin
            k <= k + KW'(1);
            if (k + KW'(1) >= stop) begin
              state <= S_DONE;
              if (op == OP_SCAN || op == OP_SCAN_INV) res.status <= ST_NOT_FOUND;
            end
          end
        end
        S_INV: begin
          k <= k + KW'(1);
          cnt <= cnt + KW'(1);
          if (cnt + KW'(1) == span) state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_word <= res;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "bit_allocation_map_engine_top_assert.svh"
  `BAME_ASSERT_IMPL(a_no_req_busy, state != S_IDLE, !req.ready, "request taken while busy")
  `BAME_ASSERT_NEXT(a_done_valid, state == S_DONE, rsp_valid, "result lost")
  `BAME_ASSERT_NEXT(a_hold_rsp, rsp_valid && !rsp.ready, rsp_valid && $stable(rsp.data),
    "result changed while stalled")
endmodule
